// ===== hdl/layer_blend_composite_assert.svh =====
// Assertion macros used by the port-level checker of the layer blend compositor.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef LAYER_BLEND_COMPOSITE_ASSERT_SVH
`define LAYER_BLEND_COMPOSITE_ASSERT_SVH

// Checked on every rising edge once reset has been released.
`define LBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LBC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lbc_pkg.sv =====
// Shared types, register codes and the rounding helper of the layer blend compositor.
// Used by every module of the block but the queue; depends on nothing.
package lbc_pkg;

	localparam int CHANNEL_BITS = 16;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef logic [CHANNEL_BITS-1:0] ch_t;

	localparam ch_t CH_MAX = '1;
	localparam logic [2*CHANNEL_BITS+1:0] RND_OFS =
		(2*CHANNEL_BITS+2)'((1 << (CHANNEL_BITS-1)) - 1);

	typedef enum logic [3:0] {
		BM_NORMAL     = 4'd0,
		BM_MULTIPLY   = 4'd1,
		BM_SCREEN     = 4'd2,
		BM_OVERLAY    = 4'd3,
		BM_DARKEN     = 4'd4,
		BM_LIGHTEN    = 4'd5,
		BM_ADD        = 4'd6,
		BM_SUBTRACT   = 4'd7,
		BM_DIFFERENCE = 4'd8
	} blend_mode_e;

	typedef enum logic [1:0] {
		REG_BLEND   = 2'd0,
		REG_IN_PM   = 2'd1,
		REG_OUT_PM  = 2'd2,
		REG_OPACITY = 2'd3
	} reg_idx_e;

	typedef struct packed {
		blend_mode_e mode;
		logic        in_pm;
		logic        out_pm;
		ch_t         opacity;
	} cfg_t;

	typedef struct packed {
		ch_t bg_red;
		ch_t bg_green;
		ch_t bg_blue;
		ch_t bg_alpha;
		ch_t fg_red;
		ch_t fg_green;
		ch_t fg_blue;
		ch_t fg_alpha;
	} pixel_in_t;

	typedef struct packed {
		ch_t out_red;
		ch_t out_green;
		ch_t out_blue;
		ch_t out_alpha;
	} pixel_out_t;

	// Straight colour handed from the front part to the back part.
	typedef struct packed {
		ch_t [2:0] bc;
		ch_t [2:0] fc;
		ch_t       ba;
		ch_t       fa;
	} mid_t;

	// Rounds p / CH_MAX to nearest with ties up, as (2p + M) / 2M.
	// The divide by 2^N - 1 is done by two folds of the upper bits and one correction.
	function automatic ch_t fx_round(input logic [2*CHANNEL_BITS:0] p);
		logic [2*CHANNEL_BITS+1:0] w;
		logic [CHANNEL_BITS+1:0]   q1;
		logic [CHANNEL_BITS+2:0]   r;
		logic [2:0]                q2;
		logic [CHANNEL_BITS:0]     r2;
		logic [CHANNEL_BITS+1:0]   q;
		w  = {1'b0, p} + RND_OFS;
		q1 = w[2*CHANNEL_BITS+1:CHANNEL_BITS];
		r  = {3'b000, w[CHANNEL_BITS-1:0]} + {1'b0, q1};
		q2 = r[CHANNEL_BITS+2:CHANNEL_BITS];
		r2 = {1'b0, r[CHANNEL_BITS-1:0]} + {(CHANNEL_BITS-2)'(0), q2};
		q  = q1 + {(CHANNEL_BITS-1)'(0), q2}
			+ {(CHANNEL_BITS+1)'(0), (r2 >= {1'b0, CH_MAX})};
		return q[CHANNEL_BITS-1:0];
	endfunction

endpackage

// ===== hdl/lbc_fifo.sv =====
// Two-entry queue used between the front and back parts and at the result side.
// Depends on nothing but its width parameter.
module lbc_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ===== hdl/lbc_fxmul.sv =====
// Registered channel multiplier with round-to-nearest rescaling by the channel maximum.
// Depends on lbc_pkg for the channel type and the rounding function.
module lbc_fxmul import lbc_pkg::*; (
	input  logic clk,
	input  logic en,
	input  ch_t  a,
	input  ch_t  b,
	output ch_t  q,
	output ch_t  q2
);

	logic [2*CHANNEL_BITS-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {CHANNEL_BITS'(0), a} * {CHANNEL_BITS'(0), b};
		end
	end

	// q is round(ab / M), q2 is round(2ab / M).
	assign q  = fx_round({1'b0, prod_q});
	assign q2 = fx_round({prod_q, 1'b0});

endmodule

// ===== hdl/lbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating at the channel maximum.
// Depends on lbc_pkg; side data travels alongside the quotient.
module lbc_div import lbc_pkg::*; #(
	parameter int XW = 2*CHANNEL_BITS + 2,
	parameter int DW = CHANNEL_BITS + 1,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XW-1:0] x,
	input  logic [DW-1:0] d,
	input  logic [SW-1:0] side_in,
	output ch_t           q,
	output logic [SW-1:0] side_out
);

	localparam int RW = ((XW > DW + CHANNEL_BITS) ? XW : DW + CHANNEL_BITS) + 1;
	localparam int NS = CHANNEL_BITS + 1;

	logic [RW-1:0] rem_q  [NS];
	logic [DW-1:0] den_q  [NS];
	ch_t           quo_q  [NS];
	logic          sat_q  [NS];
	logic [SW-1:0] side_q [NS];

	always_ff @(posedge clk) begin
		logic [RW-1:0] dsh;
		logic          ge;
		if (en) begin
			rem_q[0]  <= RW'(x);
			den_q[0]  <= d;
			quo_q[0]  <= '0;
			sat_q[0]  <= (RW'(x) >= (RW'(d) << CHANNEL_BITS));
			side_q[0] <= side_in;
			for (int k = 1; k < NS; k++) begin
				dsh = RW'(den_q[k-1]) << (CHANNEL_BITS - k);
				ge  = (rem_q[k-1] >= dsh);
				rem_q[k]  <= ge ? (rem_q[k-1] - dsh) : rem_q[k-1];
				den_q[k]  <= den_q[k-1];
				quo_q[k]  <= quo_q[k-1] | (ch_t'(ge) << (CHANNEL_BITS - k));
				sat_q[k]  <= sat_q[k-1];
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign q        = sat_q[NS-1] ? CH_MAX : quo_q[NS-1];
	assign side_out = side_q[NS-1];

endmodule

// ===== hdl/lbc_front.sv =====
// Front part: accepts pixel pairs and makes premultiplied colour straight.
// Depends on lbc_pkg and lbc_div.
module lbc_front import lbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      push,
	output logic      full,
	input  pixel_in_t pixel,
	output logic      mid_push,
	input  logic      mid_full,
	output mid_t      mid_data
);

	localparam int LAT = CHANNEL_BITS + 2;
	localparam int SW  = 2*CHANNEL_BITS + 1;

	logic [LAT-1:0] v_q;
	logic           en;
	pixel_in_t      pix_s1;
	ch_t            lane_c [6];
	ch_t            lane_a [6];
	ch_t            lane_q [6];
	logic [SW-1:0]  lane_side [6];
	ch_t            straight [6];
	ch_t            lane_alpha [6];

	assign en       = !(v_q[LAT-1] && mid_full);
	assign full     = !en;
	assign mid_push = v_q[LAT-1] && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], push};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= pixel;
		end
	end

	always_comb begin
		lane_c[0] = pix_s1.bg_red;
		lane_c[1] = pix_s1.bg_green;
		lane_c[2] = pix_s1.bg_blue;
		lane_c[3] = pix_s1.fg_red;
		lane_c[4] = pix_s1.fg_green;
		lane_c[5] = pix_s1.fg_blue;
		for (int i = 0; i < 6; i++) begin
			lane_a[i] = (i < 3) ? pix_s1.bg_alpha : pix_s1.fg_alpha;
		end
	end

	for (genvar i = 0; i < 6; i++) begin : g_lane
		logic [2*CHANNEL_BITS-1:0] cm;
		logic [2*CHANNEL_BITS+1:0] num;
		logic                      byp;

		assign cm  = {CHANNEL_BITS'(0), lane_c[i]} * {CHANNEL_BITS'(0), CH_MAX};
		assign num = {1'b0, cm, 1'b0} + {(CHANNEL_BITS+2)'(0), lane_a[i]};
		// Straight input, or zero alpha, leaves the colour as it came.
		assign byp = !cfg.in_pm || (lane_a[i] == '0);

		lbc_div #(
			.XW(2*CHANNEL_BITS + 2),
			.DW(CHANNEL_BITS + 1),
			.SW(SW)
		) u_div (
			.clk     (clk),
			.en      (en),
			.x       (num),
			.d       ({lane_a[i], 1'b0}),
			.side_in ({byp, lane_c[i], lane_a[i]}),
			.q       (lane_q[i]),
			.side_out(lane_side[i])
		);

		assign straight[i]   = lane_side[i][SW-1] ? lane_side[i][SW-2:CHANNEL_BITS]
		                                          : lane_q[i];
		assign lane_alpha[i] = lane_side[i][CHANNEL_BITS-1:0];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mid_data.bc[i] = straight[i];
			mid_data.fc[i] = straight[i+3];
		end
		mid_data.ba = lane_alpha[0];
		mid_data.fa = lane_alpha[3];
	end

endmodule

// ===== hdl/lbc_back.sv =====
// Back part: opacity, per-channel blend, source-over composite and optional premultiply.
// Depends on lbc_pkg, lbc_fxmul and lbc_div.
module lbc_back import lbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       mid_empty,
	output logic       mid_pop,
	input  mid_t       mid_data,
	input  logic       out_full,
	output logic       out_push,
	output pixel_out_t out_data
);

	localparam int LAT = CHANNEL_BITS + 8;

	logic [LAT-1:0] v_q;
	logic           en;

	mid_t m_s1;
	ch_t  fa_op;
	ch_t  bf_q [3], bf_q2 [3], inv_q [3], inv_q2 [3];
	ch_t  bc_s2 [3], fc_s2 [3];
	ch_t  ba_s2;
	ch_t  mix [3];
	ch_t  mix_s3 [3], bc_s3 [3];
	ch_t  fa_s3, ba_s3;
	ch_t  t_val;
	ch_t  mix_s4 [3], bc_s4 [3];
	ch_t  fa_s4;
	logic [CHANNEL_BITS:0] oa_sum;
	ch_t  oa;
	ch_t  mix_s5 [3], bc_s5 [3];
	ch_t  fa_s5, t_s5, oa_s5;
	logic [2*CHANNEL_BITS-1:0] pm_s6 [3], pb_s6 [3];
	ch_t  oa_s6;
	ch_t  div_q [3];
	ch_t  oa_div;
	ch_t  col [3];
	ch_t  col_s7 [3];
	ch_t  oa_s7;
	ch_t  pre_q [3];

	assign en       = !(v_q[LAT-1] && out_full);
	assign mid_pop  = !mid_empty && en;
	assign out_push = v_q[LAT-1] && !out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], mid_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= mid_data;
		end
	end

	lbc_fxmul u_opacity (
		.clk(clk), .en(en), .a(m_s1.fa), .b(cfg.opacity), .q(fa_op), .q2()
	);

	for (genvar i = 0; i < 3; i++) begin : g_blend
		lbc_fxmul u_bf (
			.clk(clk), .en(en), .a(m_s1.bc[i]), .b(m_s1.fc[i]),
			.q(bf_q[i]), .q2(bf_q2[i])
		);
		lbc_fxmul u_inv (
			.clk(clk), .en(en), .a(CH_MAX - m_s1.bc[i]), .b(CH_MAX - m_s1.fc[i]),
			.q(inv_q[i]), .q2(inv_q2[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				bc_s2[i] <= m_s1.bc[i];
				fc_s2[i] <= m_s1.fc[i];
			end
			ba_s2 <= m_s1.ba;
		end
	end

	always_comb begin
		ch_t                   b;
		ch_t                   f;
		logic [CHANNEL_BITS:0] sum;
		for (int i = 0; i < 3; i++) begin
			b   = bc_s2[i];
			f   = fc_s2[i];
			sum = {1'b0, b} + {1'b0, f};
			unique case (cfg.mode)
				BM_MULTIPLY:   mix[i] = bf_q[i];
				BM_SCREEN:     mix[i] = CH_MAX - inv_q[i];
				// The dark half of the background multiplies, the bright half screens.
				BM_OVERLAY:    mix[i] = !b[CHANNEL_BITS-1] ? bf_q2[i] : CH_MAX - inv_q2[i];
				BM_DARKEN:     mix[i] = (b < f) ? b : f;
				BM_LIGHTEN:    mix[i] = (b > f) ? b : f;
				BM_ADD:        mix[i] = sum[CHANNEL_BITS] ? CH_MAX : sum[CHANNEL_BITS-1:0];
				BM_SUBTRACT:   mix[i] = (b > f) ? b - f : '0;
				BM_DIFFERENCE: mix[i] = (b > f) ? b - f : f - b;
				default:       mix[i] = f;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mix_s3[i] <= mix[i];
				bc_s3[i]  <= bc_s2[i];
				mix_s4[i] <= mix_s3[i];
				bc_s4[i]  <= bc_s3[i];
			end
			fa_s3 <= fa_op;
			ba_s3 <= ba_s2;
			fa_s4 <= fa_s3;
		end
	end

	lbc_fxmul u_cover (
		.clk(clk), .en(en), .a(ba_s3), .b(CH_MAX - fa_s3), .q(t_val), .q2()
	);

	assign oa_sum = {1'b0, fa_s4} + {1'b0, t_val};
	assign oa     = oa_sum[CHANNEL_BITS] ? CH_MAX : oa_sum[CHANNEL_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mix_s5[i] <= mix_s4[i];
				bc_s5[i]  <= bc_s4[i];
				pm_s6[i]  <= {CHANNEL_BITS'(0), mix_s5[i]} * {CHANNEL_BITS'(0), fa_s5};
				pb_s6[i]  <= {CHANNEL_BITS'(0), bc_s5[i]} * {CHANNEL_BITS'(0), t_s5};
			end
			fa_s5 <= fa_s4;
			t_s5  <= t_val;
			oa_s5 <= oa;
			oa_s6 <= oa_s5;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_norm
		logic [2*CHANNEL_BITS:0]   num;
		logic [2*CHANNEL_BITS+1:0] x;
		ch_t                       side;

		assign num = {1'b0, pm_s6[i]} + {1'b0, pb_s6[i]};
		assign x   = {num, 1'b0} + {(CHANNEL_BITS+2)'(0), oa_s6};

		lbc_div #(
			.XW(2*CHANNEL_BITS + 2),
			.DW(CHANNEL_BITS + 1),
			.SW(CHANNEL_BITS)
		) u_div (
			.clk     (clk),
			.en      (en),
			.x       (x),
			.d       ({oa_s6, 1'b0}),
			.side_in (oa_s6),
			.q       (div_q[i]),
			.side_out(side)
		);

		// Zero result alpha gives black colour.
		assign col[i] = (side == '0) ? '0 : div_q[i];
		if (i == 0) begin : g_alpha
			assign oa_div = side;
		end

		lbc_fxmul u_pre (
			.clk(clk), .en(en), .a(col[i]), .b(side), .q(pre_q[i]), .q2()
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				col_s7[i] <= col[i];
			end
			oa_s7 <= oa_div;
		end
	end

	always_comb begin
		out_data.out_red   = cfg.out_pm ? pre_q[0] : col_s7[0];
		out_data.out_green = cfg.out_pm ? pre_q[1] : col_s7[1];
		out_data.out_blue  = cfg.out_pm ? pre_q[2] : col_s7[2];
		out_data.out_alpha = oa_s7;
	end

endmodule

// ===== hdl/layer_blend_composite.sv =====
// Top level of the layer blend compositor: register port, front part, back part, queues.
// Depends on lbc_pkg, lbc_front, lbc_back and lbc_fifo.
//
// Use of the block:
// Pixel pairs (background and foreground RGBA) are pushed on the input queue interface
// with push/full; a transaction completes on a rising edge with push high and full low.
// Composited pixels leave through empty/pop; the oldest result sits on the result port
// while empty is low and is taken on an edge with pop high.
// Registers (blend mode, input and output premultiply, layer opacity) sit on an APB-style
// port at byte addresses 0, 4, 8 and 12; the user must write them only while the block is
// idle, which the block itself does not enforce. Throughput is one pixel pair per clock
// while the receiver keeps popping: the front straightening dividers and the back
// normalising dividers are fully pipelined, one quotient bit per stage, and two-entry
// queues sit between front and back and at the result side.
// When the receiver stops popping, the result queue fills, the back part holds, then the
// middle queue fills and full rises; no transaction is lost or repeated.
// Reset clears both queues and every pipeline valid bit and sets the registers to normal
// blending, straight input and output, and full opacity.
module layer_blend_composite import lbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              push,
	output logic              full,
	input  pixel_in_t         pixel,
	input  logic              pop,
	output logic              empty,
	output pixel_out_t        result
);

	cfg_t       cfg_q;
	reg_idx_e   reg_idx;
	logic       cfg_wr;
	logic       mid_push;
	logic       mid_full;
	logic       mid_pop;
	logic       mid_empty;
	mid_t       mid_in;
	mid_t       mid_out;
	logic       out_push;
	logic       out_full;
	pixel_out_t out_data;

	// The register port never inserts wait states.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: BM_NORMAL, in_pm: 1'b0, out_pm: 1'b0, opacity: CH_MAX};
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BLEND:   cfg_q.mode    <= blend_mode_e'(pwdata[3:0]);
				REG_IN_PM:   cfg_q.in_pm   <= pwdata[0];
				REG_OUT_PM:  cfg_q.out_pm  <= pwdata[0];
				REG_OPACITY: cfg_q.opacity <= pwdata[CHANNEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read-back returns each register zero-extended.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_BLEND:   prdata[3:0]              = cfg_q.mode;
			REG_IN_PM:   prdata[0]                = cfg_q.in_pm;
			REG_OUT_PM:  prdata[0]                = cfg_q.out_pm;
			REG_OPACITY: prdata[CHANNEL_BITS-1:0] = cfg_q.opacity;
			default:     prdata                   = '0;
		endcase
	end

	// The front part straightens premultiplied colour.
	lbc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.mid_push(mid_push),
		.mid_full(mid_full),
		.mid_data(mid_in)
	);

	// The middle queue lets front and back stall independently.
	lbc_fifo #(.W($bits(mid_t))) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.din   (mid_in),
		.full  (mid_full),
		.pop   (mid_pop),
		.dout  (mid_out),
		.empty (mid_empty)
	);

	// The back part blends and composites.
	lbc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.mid_empty(mid_empty),
		.mid_pop  (mid_pop),
		.mid_data (mid_out),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (out_data)
	);

	// The result queue decouples the back part from the receiver.
	lbc_fifo #(.W($bits(pixel_out_t))) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.din   (out_data),
		.full  (out_full),
		.pop   (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule

// ===== hdl/lbc_check.sv =====
// Port-level checker for the layer blend compositor, bound to the top level.
// Depends on lbc_pkg and the assertion macros in layer_blend_composite_assert.svh.
`include "layer_blend_composite_assert.svh"

module lbc_check import lbc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready,
	input logic              pop,
	input logic              empty,
	input pixel_out_t        result
);

	logic opac_wr;
	logic opac_sel;
	ch_t  rd_opac;
	ch_t  wr_opac;

	assign opac_sel = (paddr[ADDR_W-1:2] == REG_OPACITY);
	assign opac_wr  = psel && penable && pwrite && pready && opac_sel;
	assign rd_opac  = prdata[CHANNEL_BITS-1:0];
	assign wr_opac  = pwdata[CHANNEL_BITS-1:0];

	// The register port has no wait states.
	`LBC_ASSERT_ALWAYS(a_pready_high, pready, "pready fell")

	// No result is offered while reset is held.
	`LBC_ASSERT_ALWAYS(a_empty_in_reset, !arst_n |-> empty, "result offered during reset")

	// An opacity write reads back on the following cycle.
	`LBC_ASSERT(a_opac_rb, opac_wr ##1 opac_sel |-> rd_opac == $past(wr_opac), "opacity readback")

	// A waiting result that is not taken stays as it is.
	`LBC_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(result), "result changed")

endmodule

bind layer_blend_composite lbc_check u_check (.*);

// ===== test/tb.sv =====
// Self-checking testbench of the layer blend compositor: directed table, mode sweep, then random pixels.
// Depends on lbc_pkg and the layer_blend_composite RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
	import lbc_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              push;
	logic              full;
	pixel_in_t         pixel;
	logic              pop;
	logic              empty;
	pixel_out_t        result;

	layer_blend_composite DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .pixel(pixel), .pop(pop), .empty(empty), .result(result)
	);

	localparam longint M = 65535;
	localparam int LATENCY = 2*CHANNEL_BITS + 11;
	localparam int CYCLE_LIMIT = 400000;

	// Configuration as the predictor sees it.
	logic [3:0] cur_mode;
	logic       cur_in_pm;
	logic       cur_out_pm;
	ch_t        cur_opacity;

	pixel_out_t expected_pixels[$];
	int         mismatch_count;
	int         checked_count;
	int         cycle_count;
	bit         rx_hold;
	bit         rx_calm;
	bit         tx_calm;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog: ends the run if the traffic never completes.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint mul_round(longint a, longint b);
		return (2*a*b + M) / (2*M);
	endfunction

	function automatic longint div_round_sat(longint x, longint d);
		longint q;
		q = (2*x + d) / (2*d);
		return (q > M) ? M : q;
	endfunction

	function automatic longint straight_colour(longint c, longint a);
		if (cur_in_pm && a != 0)
			return div_round_sat(c*M, a);
		return c;
	endfunction

	function automatic longint mode_mix(longint b, longint f);
		case (cur_mode)
			BM_MULTIPLY:   return mul_round(b, f);
			BM_SCREEN:     return M - mul_round(M - b, M - f);
			BM_OVERLAY: begin
				if (2*b <= M)
					return (4*b*f + M) / (2*M);
				return M - (4*(M - b)*(M - f) + M) / (2*M);
			end
			BM_DARKEN:     return (b < f) ? b : f;
			BM_LIGHTEN:    return (b > f) ? b : f;
			BM_ADD:        return (b + f > M) ? M : b + f;
			BM_SUBTRACT:   return (b > f) ? b - f : 0;
			BM_DIFFERENCE: return (b > f) ? b - f : f - b;
			default:       return f;
		endcase
	endfunction

	// Works out the composited pixel for one pixel pair under the current settings.
	function automatic pixel_out_t composite_pixel(pixel_in_t px);
		longint bc[3];
		longint fc[3];
		longint ba, fa, t, oa, c;
		pixel_out_t res;
		ba = px.bg_alpha;
		fa = px.fg_alpha;
		bc[0] = straight_colour(px.bg_red, ba);
		bc[1] = straight_colour(px.bg_green, ba);
		bc[2] = straight_colour(px.bg_blue, ba);
		fc[0] = straight_colour(px.fg_red, fa);
		fc[1] = straight_colour(px.fg_green, fa);
		fc[2] = straight_colour(px.fg_blue, fa);
		fa = mul_round(fa, cur_opacity);
		t  = mul_round(ba, M - fa);
		oa = fa + t;
		if (oa > M)
			oa = M;
		for (int i = 0; i < 3; i++) begin
			c = 0;
			if (oa != 0)
				c = div_round_sat(mode_mix(bc[i], fc[i])*fa + bc[i]*t, oa);
			if (cur_out_pm)
				c = mul_round(c, oa);
			case (i)
				0: res.out_red = ch_t'(c);
				1: res.out_green = ch_t'(c);
				default: res.out_blue = ch_t'(c);
			endcase
		end
		res.out_alpha = ch_t'(oa);
		return res;
	endfunction

	// Register write over the APB-style port; the predictor copy follows it.
	task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4*int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BLEND:  cur_mode = value[3:0];
			REG_IN_PM:  cur_in_pm = value[0];
			REG_OUT_PM: cur_out_pm = value[0];
			default:    cur_opacity = value[15:0];
		endcase
	endtask

	task automatic apply_config(logic [3:0] mode, bit in_pm, bit out_pm, ch_t opacity);
		write_reg(REG_BLEND, {28'h0, mode});
		write_reg(REG_IN_PM, {31'h0, in_pm});
		write_reg(REG_OUT_PM, {31'h0, out_pm});
		write_reg(REG_OPACITY, {16'h0, opacity});
	endtask

	// Offers one pixel pair, with random idling first, and records its outcome.
	// push stays high after acceptance so that back-to-back transactions need no gap.
	task automatic send_pixel(pixel_in_t px, bit typed, pixel_out_t typed_res);
		while (!tx_calm && $urandom_range(99) < 14) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (full);
		expected_pixels.push_back(typed ? typed_res : composite_pixel(px));
	endtask

	// Stops offering, waits until every expected result has come back, then lets the pipe drain.
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic ch_t rand_channel();
		case ($urandom_range(7))
			0: return '0;
			1: return CH_MAX;
			2: return ch_t'($urandom_range(255));
			3: return CH_MAX - ch_t'($urandom_range(255));
			4: return ch_t'(16'h7FFF + $urandom_range(2));
			default: return ch_t'($urandom);
		endcase
	endfunction

	function automatic pixel_in_t rand_pixel();
		pixel_in_t px;
		px.bg_alpha = rand_channel();
		px.fg_alpha = rand_channel();
		px.bg_red = rand_channel();
		px.bg_green = rand_channel();
		px.bg_blue = rand_channel();
		px.fg_red = rand_channel();
		px.fg_green = rand_channel();
		px.fg_blue = rand_channel();
		// With premultiplied input, colour normally stays at or under alpha.
		if (cur_in_pm && $urandom_range(3) != 0) begin
			px.bg_red   = ch_t'((longint'(px.bg_red) * px.bg_alpha) / M);
			px.bg_green = ch_t'((longint'(px.bg_green) * px.bg_alpha) / M);
			px.bg_blue  = ch_t'((longint'(px.bg_blue) * px.bg_alpha) / M);
			px.fg_red   = ch_t'((longint'(px.fg_red) * px.fg_alpha) / M);
			px.fg_green = ch_t'((longint'(px.fg_green) * px.fg_alpha) / M);
			px.fg_blue  = ch_t'((longint'(px.fg_blue) * px.fg_alpha) / M);
		end
		return px;
	endfunction

	// Receiver: pops with random idling, and holds off for long stretches when asked.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				checked_count++;
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Unexpected result %h", result);
				end else begin
					pixel_out_t want;
					want = expected_pixels.pop_front();
					if (result !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("Mismatch: expected %h %h %h %h, got %h %h %h %h",
								want.out_red, want.out_green, want.out_blue, want.out_alpha,
								result.out_red, result.out_green, result.out_blue,
								result.out_alpha);
					end
				end
			end
			pop <= !rx_hold && (rx_calm || $urandom_range(99) >= 14);
		end
	end

	typedef struct {
		pixel_in_t  px;
		bit         typed;
		pixel_out_t res;
	} directed_row_t;

	directed_row_t directed_rows[$];
	int            phase;
	int            hold_cycles;

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		pixel = '0;
		pop = 1'b0;
		rx_hold = 1'b0;
		rx_calm = 1'b0;
		tx_calm = 1'b0;
		mismatch_count = 0;
		checked_count = 0;
		cycle_count = 0;
		cur_mode = BM_NORMAL;
		cur_in_pm = 1'b0;
		cur_out_pm = 1'b0;
		cur_opacity = CH_MAX;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under reset settings: typed results where obvious.
		directed_rows.push_back('{'0, 1'b1, '0});
		directed_rows.push_back('{'1, 1'b1, '1});
		// Opaque foreground in normal mode shows the foreground.
		directed_rows.push_back('{{16'h1234, 16'h5678, 16'h9ABC, 16'hFFFF,
			16'h1111, 16'h2222, 16'h3333, 16'hFFFF}, 1'b1,
			{16'h1111, 16'h2222, 16'h3333, 16'hFFFF}});
		// Transparent foreground shows the background.
		directed_rows.push_back('{{16'h1234, 16'h5678, 16'h9ABC, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1,
			{16'h1234, 16'h5678, 16'h9ABC, 16'hFFFF}});
		// Both alphas zero: colour forced to zero.
		directed_rows.push_back('{{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, '0});
		directed_rows.push_back('{{16'h8000, 16'h7FFF, 16'h0001, 16'h8000,
			16'hFFFE, 16'h0001, 16'h8000, 16'h7FFF}, 1'b0, '0});
		foreach (directed_rows[i])
			send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].res);
		wait_drained();

		// Every mode, including unknown codes, with input and output premultiply taken from the code's low bits.
		for (int m = 0; m < 16; m++) begin
			apply_config(m[3:0], m[0], m[1], (m == 15) ? 16'h0000 : ch_t'(16'h8000 + m));
			send_pixel('{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
				16'h4000, 16'hC000, 16'h0000, 16'h0000}, 1'b0, '0);
			send_pixel('{16'h9000, 16'h3000, 16'h0100, 16'h8000,
				16'hA000, 16'h0200, 16'hFFFF, 16'h9000}, 1'b0, '0);
			wait_drained();
		end

		// Random phases, each under its own settings, extremes included.
		for (phase = 0; phase < 12; phase++) begin
			case (phase)
				0: apply_config(BM_NORMAL, 1'b0, 1'b0, CH_MAX);
				1: apply_config(BM_DIFFERENCE, 1'b1, 1'b1, '0);
				default: apply_config(4'($urandom_range(15)), 1'($urandom),
					1'($urandom), ($urandom_range(3) == 0) ? CH_MAX : rand_channel());
			endcase
			tx_calm = (phase == 3);
			rx_calm = (phase == 3);
			if (phase == 5) begin
				// Receiver holds off while the sender keeps pushing, filling the pipe.
				fork
					begin
						rx_hold = 1'b1;
						hold_cycles = 0;
						while (hold_cycles < 200) begin
							@(posedge clk);
							hold_cycles++;
						end
						rx_hold = 1'b0;
					end
				join_none
			end
			for (int n = 0; n < 100; n++)
				send_pixel(rand_pixel(), 1'b0, '0);
			tx_calm = 1'b0;
			rx_calm = 1'b0;
			// The sender pauses here until all results are back.
			wait_drained();
		end

		$display("Checked %0d composited pixels over all blend modes, premultiply settings",
			checked_count);
		$display("and opacities, with back-pressure and random idling on both sides.");
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
